// File: sv/msbp_pkg.sv
// shared types, constants and sequencer states of the msb-first bit field packer
package msbp_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned CLASS_W = 2;
	localparam int unsigned CAP_W   = 16;
	localparam int unsigned USED_W  = 19;
	localparam int unsigned FILL_W  = 3;
	localparam int unsigned WIN_W   = VALUE_W + 8;
	localparam int unsigned LEFT_W  = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_MERGE,
		ST_EMIT
	} msbp_state_t;

endpackage

// File: sv/msbp_req_if.sv
// input channel: one field to append per beat
interface msbp_req_if;
	import msbp_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] field_value;
	logic [COUNT_W-1:0] bit_count;
	logic [CLASS_W-1:0] width_class;

	modport source (output valid, output field_value, output bit_count, output width_class,
		input ready);
	modport sink (input valid, input field_value, input bit_count, input width_class,
		output ready);
endinterface

// File: sv/msbp_rsp_if.sv
// output channel: one completed byte or status per beat
interface msbp_rsp_if;
	import msbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [7:0]        byte_out;
	logic              byte_valid;
	logic [CAP_W-1:0]  byte_index;
	logic              accepted;
	logic [7:0]        partial_byte;
	logic [FILL_W-1:0] partial_bits;
	logic [USED_W-1:0] bits_used;
	logic              last;

	modport source (output valid, output byte_out, output byte_valid, output byte_index,
		output accepted, output partial_byte, output partial_bits, output bits_used,
		output last, input ready);
	modport sink (input valid, input byte_out, input byte_valid, input byte_index,
		input accepted, input partial_byte, input partial_bits, input bits_used,
		input last, output ready);
endinterface

// File: sv/msb_first_bit_field_packer.sv
// top level: msb-first bit field packer with a byte-per-cycle emit sequencer
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    field_value, bit_count, width_class
//  rsp      out  valid/ready    byte_out, byte_valid, byte_index, accepted,
//                               partial_byte, partial_bits, bits_used, last
//  cfg      in   cfg_we         cfg_wdata = capacity_bytes
//
// an accepted item passes through the align, merge and emit steps and gives max(1, n) beats
// before the next ready, n being the number of bytes it completes (at most 8); a rejected
// item skips the merge step and gives one beat. the 72-bit window shifter emits one byte per
// cycle while rsp does not stall.
// a stalled rsp holds the sequencer in its emit step; the last beat of an item sits
// in the output register while the next item is taken.
// arst_n clears the sequencer, the bit state and sets capacity to 4096 bytes;
// a cfg write loads the capacity and clears the bit state, but not the sequencer.
module msb_first_bit_field_packer
	import msbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	msbp_req_if.sink         req,
	msbp_rsp_if.source       rsp
);

	msbp_state_t state_q, state_d;

	logic [CAP_W-1:0]   cap_q;
	logic [7:0]         pend_q;
	logic [FILL_W-1:0]  fill_q;
	logic [USED_W-1:0]  used_q;

	logic [VALUE_W-1:0] aligned_q;
	logic [7:0]         val_lo_q;
	logic [COUNT_W-1:0] count_q;
	logic [CLASS_W-1:0] class_q;
	logic [WIN_W-1:0]   win_q;
	logic [CAP_W-1:0]   idx_q;
	logic [LEFT_W-1:0]  left_q;
	logic               acc_q;

	logic               ovalid_q;
	logic [7:0]         obyte_q;
	logic               obvalid_q;
	logic [CAP_W-1:0]   oindex_q;
	logic               oacc_q;
	logic [7:0]         opart_q;
	logic [FILL_W-1:0]  ofill_q;
	logic [USED_W-1:0]  oused_q;
	logic               olast_q;

	logic               take;
	logic               slot_free;
	logic               load_out;
	logic               fits;
	logic [COUNT_W-1:0] width;
	logic [USED_W-1:0]  room;
	logic [COUNT_W-1:0] total;
	logic [WIN_W-1:0]   merged;
	logic [FILL_W-1:0]  new_fill;
	logic [LEFT_W-1:0]  new_left;

	assign take      = req.valid && req.ready;
	assign slot_free = !ovalid_q || rsp.ready;

	// width and space check on the latched item
	assign width = COUNT_W'(8) << class_q;
	assign room  = {cap_q, 3'b000} - used_q;
	assign fits  = (count_q <= width) && (USED_W'(count_q) <= room);

	// merge of the pending bits and the aligned field
	assign merged   = {pend_q, {VALUE_W{1'b0}}} | ({aligned_q, 8'h00} >> fill_q);
	assign total    = COUNT_W'(fill_q) + count_q;
	assign new_fill = total[FILL_W-1:0];
	assign new_left = total[COUNT_W-1:FILL_W];

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				state_d = fits ? ST_MERGE : ST_EMIT;
			end
			ST_MERGE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (left_q <= LEFT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capacity register and packer bit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			pend_q <= 8'h00;
			fill_q <= '0;
			used_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cfg_wdata;
			pend_q <= 8'h00;
			fill_q <= '0;
			used_q <= '0;
		end else if (state_q == ST_MERGE) begin
			fill_q <= new_fill;
			used_q <= used_q + USED_W'(count_q);
			if (new_left == '0) begin
				pend_q <= merged[WIN_W-1 -: 8];
			end else begin
				pend_q <= val_lo_q << (4'd8 - {1'b0, new_fill});
			end
		end
	end

	// item latch, alignment and window shifter
	always_ff @(posedge clk) begin
		if (take) begin
			aligned_q <= req.field_value;
			val_lo_q  <= req.field_value[7:0];
			count_q   <= req.bit_count;
			class_q   <= req.width_class;
		end else if (state_q == ST_ALIGN) begin
			aligned_q <= aligned_q << (COUNT_W'(64) - count_q);
		end
		case (state_q)
			ST_ALIGN: begin
				left_q <= '0;
				acc_q  <= fits;
			end
			ST_MERGE: begin
				win_q  <= merged;
				idx_q  <= used_q[USED_W-1:FILL_W];
				left_q <= new_left;
			end
			ST_EMIT: begin
				if (load_out) begin
					win_q  <= win_q << 8;
					idx_q  <= idx_q + CAP_W'(1);
					left_q <= left_q - LEFT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// beat payload, bit state captured with the beat so a waiting beat keeps it
	always_ff @(posedge clk) begin
		if (load_out) begin
			obvalid_q <= (left_q != '0);
			obyte_q   <= (left_q != '0) ? win_q[WIN_W-1 -: 8] : 8'h00;
			oindex_q  <= (left_q != '0) ? idx_q : '0;
			oacc_q    <= acc_q;
			opart_q   <= pend_q;
			ofill_q   <= fill_q;
			oused_q   <= used_q;
			olast_q   <= (left_q <= LEFT_W'(1));
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.byte_out     = obyte_q;
	assign rsp.byte_valid   = obvalid_q;
	assign rsp.byte_index   = oindex_q;
	assign rsp.accepted     = oacc_q;
	assign rsp.partial_byte = opart_q;
	assign rsp.partial_bits = ofill_q;
	assign rsp.bits_used    = oused_q;
	assign rsp.last         = olast_q;

	// bit state stays consistent
	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q[FILL_W-1:0] == fill_q)
		else $error("pending fill out of step with bit total");

	a_empty_pending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (pend_q == 8'h00))
		else $error("pending byte holds bits while empty");

	a_within_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= {cap_q, 3'b000})
		else $error("bit total beyond capacity");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (left_q <= LEFT_W'(8)))
		else $error("more than eight bytes pending for one item");

endmodule
